>>> sv/bbox_quadtile_enumerator_macros.svh
// assertion helpers shared by the rtl
`ifndef BBOX_QUADTILE_ENUMERATOR_MACROS_SVH
`define BBOX_QUADTILE_ENUMERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define BQE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, checked out of reset
`define BQE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

>>> sv/bqe_pkg.sv
package bqe_pkg;

   localparam int LON_STEP_LOG = 5;
   localparam int LAT_STEP_LOG = 6;

   localparam int COORD_W     = 16;
   localparam int CUR_W       = 17;
   localparam int SUM_W       = 18;
   localparam int FACET_W     = 10;
   localparam int FBITS_W     = 4;
   localparam int IDX_LOW_W   = 3;
   localparam int QUAD_W      = 32;
   localparam int GRAN_W      = 5;
   localparam int PART_W      = 6;

   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 88;

   localparam logic [SUM_W-1:0] LON_STEP = SUM_W'(1) << LON_STEP_LOG;
   localparam logic [SUM_W-1:0] LAT_STEP = SUM_W'(1) << LAT_STEP_LOG;

   localparam logic [FBITS_W-1:0] FBITS_RESET = 4'd3;
   localparam logic [FBITS_W-1:0] FBITS_MIN   = 4'd3;

   localparam logic [GRAN_W-1:0] GRAN_T0 = 5'd18;
   localparam logic [GRAN_W-1:0] GRAN_T1 = 5'd16;
   localparam logic [GRAN_W-1:0] GRAN_T2 = 5'd14;
   localparam logic [GRAN_W-1:0] GRAN_T3 = 5'd12;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_NEXT = 1'b1;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_REJECT = 2'd1,
      ST_TILE   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   localparam logic [2:0] SPLIT_TABLE [32] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd5, 3'd5, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
   };

   typedef struct packed {
      logic [QUAD_W-1:0] quadtile;
      logic [GRAN_W-1:0] granularity;
      logic [PART_W-1:0] partition;
   } tile_info_type;

endpackage

>>> sv/bqe_tile_calc.sv
module bqe_tile_calc (
   input  logic [bqe_pkg::COORD_W-1:0]   lon,
   input  logic [bqe_pkg::COORD_W-1:0]   lat,
   input  logic [bqe_pkg::IDX_LOW_W-1:0] col_low,
   input  logic [bqe_pkg::IDX_LOW_W-1:0] row_low,
   input  logic [bqe_pkg::FACET_W-1:0]   facet,
   input  logic [bqe_pkg::FBITS_W-1:0]   facet_bits,
   output bqe_pkg::tile_info_type        info
);

   logic [bqe_pkg::QUAD_W-1:0]    quad;
   logic [bqe_pkg::IDX_LOW_W-1:0] zmask;
   logic [bqe_pkg::GRAN_W-1:0]    gran;
   logic [bqe_pkg::FBITS_W-1:0]   fb_eff;
   logic [bqe_pkg::FBITS_W-1:0]   fshift;
   logic [bqe_pkg::FACET_W-1:0]   fshifted;

   // longitude on odd bits, latitude on even bits
   always_comb begin
      quad = '0;
      for (int b = 0; b < bqe_pkg::COORD_W; b++) begin
         quad[2*b+1] = lon[b];
         quad[2*b]   = lat[b];
      end
   end

   // common trailing zeros of the column and row indices, capped at three
   assign zmask = col_low | row_low;

   always_comb begin
      if (zmask[0]) begin
         gran = bqe_pkg::GRAN_T0;
      end else if (zmask[1]) begin
         gran = bqe_pkg::GRAN_T1;
      end else if (zmask[2]) begin
         gran = bqe_pkg::GRAN_T2;
      end else begin
         gran = bqe_pkg::GRAN_T3;
      end
   end

   assign fb_eff   = (facet_bits < bqe_pkg::FBITS_MIN) ? bqe_pkg::FBITS_MIN : facet_bits;
   assign fshift   = fb_eff - bqe_pkg::FBITS_MIN;
   assign fshifted = facet >> fshift;

   assign info.quadtile    = quad;
   assign info.granularity = gran;
   assign info.partition   = {bqe_pkg::SPLIT_TABLE[quad[31:27]], fshifted[2:0]};

endmodule

>>> sv/bbox_quadtile_enumerator.sv
// channel  | direction | handshake               | payload
// req      | in        | req_tvalid/req_tready   | req_tdata, req_tuser (cmd)
// rsp      | out       | rsp_tvalid/rsp_tready   | rsp_tdata, rsp_tuser (status), rsp_tlast
// csr      | in        | csr_valid/csr_ready     | csr_data (facet_bits)
//
// one item per cycle while the output is not stalled: each accepted item is worked out in the same cycle from
// the box state and is registered in the result register.
// req_tready is high while the result register is empty or being drained.
// reset (synchronous) clears the box, drops any pending result, facet_bits = 3.
// csr_ready is always high.
`include "bbox_quadtile_enumerator_macros.svh"

module bbox_quadtile_enumerator (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // facet_id, lat_lo_q, lat_hi_q, lon_lo_q, lon_hi_q, zero pad
   input  logic [bqe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic                             req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // quadtile, granularity, partition, tile_facet, tile_lon_q, tile_lat_q, zero pad
   output logic [bqe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tlast,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bqe_pkg::FBITS_W-1:0]      csr_data
);

   localparam int CW = bqe_pkg::COORD_W;

   logic [bqe_pkg::FBITS_W-1:0]   facet_bits_ff;
   logic [CW-1:0]                 box_lat_lo_ff, box_lat_lo_in;
   logic [CW-1:0]                 box_lat_hi_ff, box_lat_hi_in;
   logic [CW-1:0]                 box_lon_hi_ff, box_lon_hi_in;
   logic [bqe_pkg::CUR_W-1:0]     cur_lon_ff, cur_lon_in;
   logic [bqe_pkg::CUR_W-1:0]     cur_lat_ff, cur_lat_in;
   logic [bqe_pkg::IDX_LOW_W-1:0] col_low_ff, col_low_in;
   logic [bqe_pkg::IDX_LOW_W-1:0] row_low_ff, row_low_in;
   logic [bqe_pkg::FACET_W-1:0]   held_facet_ff, held_facet_in;
   logic                          active_ff, active_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bqe_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   bqe_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_xfer;
   logic [bqe_pkg::FACET_W-1:0]   in_facet;
   logic [CW-1:0]                 in_lat_lo, in_lat_hi, in_lon_lo, in_lon_hi;
   logic [bqe_pkg::SUM_W-1:0]     nlat, nlon;
   logic                          lat_wrap, lon_done;
   bqe_pkg::tile_info_type        info;

   assign in_facet  = req_tdata[9:0];
   assign in_lat_lo = req_tdata[25:10];
   assign in_lat_hi = req_tdata[41:26];
   assign in_lon_lo = req_tdata[57:42];
   assign in_lon_hi = req_tdata[73:58];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   bqe_tile_calc u_calc (
      .lon        (cur_lon_ff[CW-1:0]),
      .lat        (cur_lat_ff[CW-1:0]),
      .col_low    (col_low_ff),
      .row_low    (row_low_ff),
      .facet      (held_facet_ff),
      .facet_bits (facet_bits_ff),
      .info       (info)
   );

   assign nlat     = {1'b0, cur_lat_ff} + bqe_pkg::LAT_STEP;
   assign nlon     = {1'b0, cur_lon_ff} + bqe_pkg::LON_STEP;
   assign lat_wrap = nlat > {2'b00, box_lat_hi_ff};
   assign lon_done = nlon > {2'b00, box_lon_hi_ff};

   always_comb begin
      box_lat_lo_in = box_lat_lo_ff;
      box_lat_hi_in = box_lat_hi_ff;
      box_lon_hi_in = box_lon_hi_ff;
      cur_lon_in    = cur_lon_ff;
      cur_lat_in    = cur_lat_ff;
      col_low_in    = col_low_ff;
      row_low_in    = row_low_ff;
      held_facet_in = held_facet_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_last_in  = 1'b0;
         if (req_tuser == bqe_pkg::CMD_LOAD) begin
            held_facet_in = in_facet;
            box_lat_lo_in = in_lat_lo;
            box_lat_hi_in = in_lat_hi;
            box_lon_hi_in = in_lon_hi;
            cur_lon_in    = {1'b0, in_lon_lo};
            cur_lat_in    = {1'b0, in_lat_lo};
            col_low_in    = '0;
            row_low_in    = '0;
            if (in_lat_lo > in_lat_hi || in_lon_lo > in_lon_hi) begin
               active_in     = 1'b0;
               rsp_status_in = bqe_pkg::ST_REJECT;
            end else begin
               active_in     = 1'b1;
               rsp_status_in = bqe_pkg::ST_ACCEPT;
            end
         end else if (!active_ff) begin
            rsp_status_in = bqe_pkg::ST_EMPTY;
         end else begin
            rsp_status_in = bqe_pkg::ST_TILE;
            rsp_data_in   = {3'b000, cur_lat_ff[CW-1:0], cur_lon_ff[CW-1:0],
                             held_facet_ff, info.partition, info.granularity,
                             info.quadtile};
            // latitude restarts at the low bound for every column
            if (lat_wrap) begin
               cur_lat_in = {1'b0, box_lat_lo_ff};
               row_low_in = '0;
               col_low_in = col_low_ff + 3'd1;
               cur_lon_in = nlon[bqe_pkg::CUR_W-1:0];
               if (lon_done) begin
                  active_in   = 1'b0;
                  rsp_last_in = 1'b1;
               end
            end else begin
               cur_lat_in = nlat[bqe_pkg::CUR_W-1:0];
               row_low_in = row_low_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         facet_bits_ff <= bqe_pkg::FBITS_RESET;
         box_lat_lo_ff <= '0;
         box_lat_hi_ff <= '0;
         box_lon_hi_ff <= '0;
         cur_lon_ff    <= '0;
         cur_lat_ff    <= '0;
         col_low_ff    <= '0;
         row_low_ff    <= '0;
         held_facet_ff <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            facet_bits_ff <= csr_data;
         end
         box_lat_lo_ff <= box_lat_lo_in;
         box_lat_hi_ff <= box_lat_hi_in;
         box_lon_hi_ff <= box_lon_hi_in;
         cur_lon_ff    <= cur_lon_in;
         cur_lat_ff    <= cur_lat_in;
         col_low_ff    <= col_low_in;
         row_low_ff    <= row_low_in;
         held_facet_ff <= held_facet_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BQE_ASSERT_SAME(a_last_only_on_tile, clock, reset,
      rsp_valid_ff && rsp_last_ff, rsp_status_ff == bqe_pkg::ST_TILE)

   `BQE_ASSERT_SAME(a_gran_legal, clock, reset,
      rsp_valid_ff && rsp_status_ff == bqe_pkg::ST_TILE,
      rsp_data_ff[36:32] == bqe_pkg::GRAN_T0 || rsp_data_ff[36:32] == bqe_pkg::GRAN_T1 ||
      rsp_data_ff[36:32] == bqe_pkg::GRAN_T2 || rsp_data_ff[36:32] == bqe_pkg::GRAN_T3)

   `BQE_ASSERT_NEXT(a_idle_next_empty, clock, reset,
      req_xfer && req_tuser == bqe_pkg::CMD_NEXT && !active_ff,
      rsp_valid_ff && rsp_status_ff == bqe_pkg::ST_EMPTY)

   `BQE_ASSERT_NEXT(a_last_ends_box, clock, reset,
      req_xfer && req_tuser == bqe_pkg::CMD_NEXT && active_ff && lat_wrap && lon_done,
      !active_ff && rsp_last_ff)

endmodule
